@@ rtl/btpc_pkg.sv @@
`default_nettype none
package btpc_pkg;

    localparam int unsigned DV_BITS = 32;

    localparam logic [1:0] CFG_TEMP_CALIB  = 2'd0;
    localparam logic [1:0] CFG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] CFG_PRESS_MID   = 2'd2;
    localparam logic [1:0] CFG_PRESS_HIGH  = 2'd3;

    localparam logic [31:0] K_PA_OFFSET  = 32'd64000;
    localparam logic [31:0] K_ADC_FULL   = 32'd1048576;
    localparam logic [31:0] K_P_SCALE    = 32'd3125;
    localparam logic [31:0] K_SIGN_BIT   = 32'h8000_0000;
    localparam logic [31:0] K_P1_OFFSET  = 32'd32768;
    localparam logic [31:0] K_T_ROUND    = 32'd128;

    // one slot of the restoring divider
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
        logic [31:0] dvs;
        logic [31:0] temp;
        logic        inv;
        logic        br2;
    } t_dv;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] f;
        f = a * b;
        return f[31:0];
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

    // one quotient bit per call
    function automatic t_dv dv_step(input t_dv s);
        t_dv         r;
        logic [32:0] t;
        logic [32:0] d;
        r = s;
        t = {s.rem, s.quo[31]};
        d = t - {1'b0, s.dvs};
        if (!d[32]) begin
            r.rem = d[31:0];
            r.quo = {s.quo[30:0], 1'b1};
        end else begin
            r.rem = t[31:0];
            r.quo = {s.quo[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/baro_temp_press_compensation_unit.sv @@
`default_nettype none
// Barometric temperature and pressure compensation, 32-bit integer scheme.
// Write the four calibration registers through i_cfg_we / i_cfg_addr /
// i_cfg_wdata while no reading pair is in flight; they are used directly.
// Input: pulse start with a raw temperature and pressure pair; the pair is
// taken at each edge where start is high and busy is low. busy stays low,
// so a new pair may enter on every cycle.
// Output: o_valid marks one result beat carrying temperature in 0.01 degC,
// pressure in Pa and the zero-divisor flag. Each beat passes through 10
// front stages (input capture, then multiply/shift/add for the temperature
// and pressure terms), one divider setup stage, 32 one-bit restoring
// divider stages, and 3 stages of final pressure correction.
// Throughput is one pair per cycle.
// Reset clears all stage valid bits and the calibration registers to 0.
// The receiver cannot stall: each beat is present for exactly one cycle.
module baro_temp_press_compensation_unit
    import btpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [19:0] i_adc_temp,
    input  wire logic [19:0] i_adc_press,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [63:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [31:0]      o_temp_centi_deg,
    output logic [31:0]      o_press_pascal,
    output logic             o_press_invalid
);

    logic [47:0] r_tcal;
    logic [63:0] r_pcal_lo, r_pcal_mid;
    logic [15:0] r_pcal_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal     <= '0;
            r_pcal_lo  <= '0;
            r_pcal_mid <= '0;
            r_pcal_hi  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TEMP_CALIB: r_tcal     <= i_cfg_wdata[47:0];
                CFG_PRESS_LOW:  r_pcal_lo  <= i_cfg_wdata;
                CFG_PRESS_MID:  r_pcal_mid <= i_cfg_wdata;
                CFG_PRESS_HIGH: r_pcal_hi  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_tcal[15:0]};
    assign t2 = sx16(r_tcal[31:16]);
    assign t3 = sx16(r_tcal[47:32]);
    assign p1 = {16'd0, r_pcal_lo[15:0]};
    assign p2 = sx16(r_pcal_lo[31:16]);
    assign p3 = sx16(r_pcal_lo[47:32]);
    assign p4 = sx16(r_pcal_lo[63:48]);
    assign p5 = sx16(r_pcal_mid[15:0]);
    assign p6 = sx16(r_pcal_mid[31:16]);
    assign p7 = sx16(r_pcal_mid[47:32]);
    assign p8 = sx16(r_pcal_mid[63:48]);
    assign p9 = sx16(r_pcal_hi);

    assign busy = 1'b0;

    // valid bits of the front stages
    logic [9:0] r_v;

    logic [19:0] r_at0, r_ap0, r_ap1, r_ap2, r_ap3, r_ap4, r_ap5, r_ap6, r_ap7;
    logic [31:0] r_m1, r_dd1;
    logic [31:0] r_a2, r_bp2;
    logic [31:0] r_fine3;
    logic [31:0] r_temp4, r_pa4;
    logic [31:0] r_temp5, r_sq5, r_mp5_5, r_mp2_5;
    logic [31:0] r_temp6, r_b1_6, r_mp3_6, r_mp5_6, r_mp2_6;
    logic [31:0] r_temp7, r_b7, r_a7;
    logic [31:0] r_temp8, r_dvs8, r_num8;
    logic [31:0] r_temp9, r_dvs9, r_p9;

    logic [31:0] n_d, n_sq, n_pa, n_b, n_a, n_q, n_fine_a;
    always_comb begin
        n_d      = {12'd0, r_at0 >> 4} - t1;
        n_fine_a = 32'($signed(r_a2) + ($signed(r_bp2) >>> 14));
        n_pa     = 32'($signed(r_fine3) >>> 1) - K_PA_OFFSET;
        n_q      = 32'($signed(r_pa4) >>> 2);
        n_sq     = mul32(n_q, n_q);
        n_b      = 32'($signed(r_b1_6 + {r_mp5_6[30:0], 1'b0}) >>> 2) + {p4[15:0], 16'd0};
        n_a      = 32'(($signed(32'($signed(r_mp3_6) >>> 3) + 32'($signed(r_mp2_6) >>> 1)))
                       >>> 18);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[8:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_at0   <= i_adc_temp;
        r_ap0   <= i_adc_press;
        // temperature terms
        r_m1    <= mul32({12'd0, r_at0 >> 3} - {t1[30:0], 1'b0}, t2);
        r_dd1   <= mul32(n_d, n_d);
        r_ap1   <= r_ap0;
        r_a2    <= 32'($signed(r_m1) >>> 11);
        r_bp2   <= mul32(32'($signed(r_dd1) >>> 12), t3);
        r_ap2   <= r_ap1;
        r_fine3 <= n_fine_a;
        r_ap3   <= r_ap2;
        r_temp4 <= 32'($signed(mul32(r_fine3, 32'd5) + K_T_ROUND) >>> 8);
        r_pa4   <= n_pa;
        r_ap4   <= r_ap3;
        // pressure terms
        r_temp5 <= r_temp4;
        r_sq5   <= n_sq;
        r_mp5_5 <= mul32(r_pa4, p5);
        r_mp2_5 <= mul32(p2, r_pa4);
        r_ap5   <= r_ap4;
        r_temp6 <= r_temp5;
        r_b1_6  <= mul32(32'($signed(r_sq5) >>> 11), p6);
        r_mp3_6 <= mul32(p3, 32'($signed(r_sq5) >>> 13));
        r_mp5_6 <= r_mp5_5;
        r_mp2_6 <= r_mp2_5;
        r_ap6   <= r_ap5;
        r_temp7 <= r_temp6;
        r_b7    <= n_b;
        r_a7    <= n_a;
        r_ap7   <= r_ap6;
        r_temp8 <= r_temp7;
        r_dvs8  <= 32'($signed(mul32(K_P1_OFFSET + r_a7, p1)) >>> 15);
        r_num8  <= (K_ADC_FULL - {12'd0, r_ap7}) - 32'($signed(r_b7) >>> 12);
        r_temp9 <= r_temp8;
        r_dvs9  <= r_dvs8;
        r_p9    <= mul32(r_num8, K_P_SCALE);
    end

    // divider pipeline
    t_dv          r_dv [0:DV_BITS];
    logic [DV_BITS:0] r_dv_v;
    t_dv          n_dv0;

    always_comb begin
        n_dv0.rem  = '0;
        n_dv0.dvs  = r_dvs9;
        n_dv0.temp = r_temp9;
        n_dv0.inv  = (r_dvs9 == '0);
        n_dv0.br2  = (r_p9 >= K_SIGN_BIT);
        n_dv0.quo  = n_dv0.br2 ? r_p9 : {r_p9[30:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v <= '0;
        end else begin
            r_dv_v <= {r_dv_v[DV_BITS-1:0], r_v[9]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv[0] <= n_dv0;
        for (int k = 0; k < DV_BITS; k++) begin
            r_dv[k+1] <= dv_step(r_dv[k]);
        end
    end

    // final correction
    logic        r_v_c1, r_v_c2;
    logic [31:0] r_p_c1, r_s_c1, r_m8_c1, r_temp_c1;
    logic [31:0] r_p_c2, r_a_c2, r_b_c2, r_temp_c2;
    logic        r_inv_c1, r_inv_c2;
    logic [31:0] n_p, n_p3, n_corr;

    always_comb begin
        n_p    = r_dv[DV_BITS].br2 ? {r_dv[DV_BITS].quo[30:0], 1'b0} : r_dv[DV_BITS].quo;
        n_p3   = n_p >> 3;
        n_corr = 32'($signed(r_a_c2 + r_b_c2 + p7) >>> 4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c1  <= 1'b0;
            r_v_c2  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v_c1  <= r_dv_v[DV_BITS];
            r_v_c2  <= r_v_c1;
            o_valid <= r_v_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_c1    <= n_p;
        r_s_c1    <= mul32(n_p3, n_p3) >> 13;
        r_m8_c1   <= mul32(n_p >> 2, p8);
        r_temp_c1 <= r_dv[DV_BITS].temp;
        r_inv_c1  <= r_dv[DV_BITS].inv;
        r_p_c2    <= r_p_c1;
        r_a_c2    <= 32'($signed(mul32(p9, r_s_c1)) >>> 12);
        r_b_c2    <= 32'($signed(r_m8_c1) >>> 13);
        r_temp_c2 <= r_temp_c1;
        r_inv_c2  <= r_inv_c1;
        o_temp_centi_deg <= r_temp_c2;
        o_press_pascal   <= r_inv_c2 ? '0 : r_p_c2 + n_corr;
        o_press_invalid  <= r_inv_c2;
    end

`ifndef NO_ASSERTIONS
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_press_invalid |-> o_press_pascal == '0)
        else $error("invalid pressure beat carries nonzero value");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_v[DV_BITS] && !r_dv[DV_BITS].inv |-> r_dv[DV_BITS].rem < r_dv[DV_BITS].dvs)
        else $error("divider remainder not below divisor");

    a_div_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_v[DV_BITS] |=> ##2 o_valid)
        else $error("divider beat lost before output");

    a_front_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[9] |=> r_dv_v[0] && (r_dv[0].inv == (r_dv[0].dvs == '0)))
        else $error("divider entry lost or flag wrong");
`endif

endmodule
`default_nettype wire
